// ----- hw/rtl/acss_pkg.sv -----
package acss_pkg;

  // Fixed field widths.
  localparam int CH_W     = 3;
  localparam int MASK_W   = 6;
  localparam int CNT_W    = 8;
  localparam int BYTE_W   = 8;
  localparam int SAMPLE_W = 16;

  // Default number of scanned channels.
  localparam int CHANNELS_DEF = 6;

  // Configuration port.
  localparam int ADDR_W  = 4;
  localparam int PDATA_W = 32;
  localparam int REG_W   = 2;
  localparam logic [REG_W-1:0] REG_ENABLE_MASK = 2'd0;
  localparam logic [REG_W-1:0] REG_SAMPLING    = 2'd1;
  localparam logic [REG_W-1:0] REG_EIGHT_BIT   = 2'd2;

  // Scan steps.
  typedef enum logic [2:0] {
    STEP_INIT     = 3'd0,
    STEP_SAMPLING = 3'd1,
    STEP_CONFIG   = 3'd2,
    STEP_WAIT     = 3'd3,
    STEP_READ     = 3'd4
  } step_t;

  // Configuration registers as seen by the sequencer.
  typedef struct packed {
    logic [MASK_W-1:0] enable_mask;
    logic [CNT_W-1:0]  sampling_ticks;
    logic              eight_bit_mode;
  } cfg_t;

  // Per-tick outcome of the sequencer.
  typedef struct packed {
    logic                start;
    logic                stored;
    logic [CH_W-1:0]     mux;
    logic [CH_W-1:0]     wr_ch;
    logic [SAMPLE_W-1:0] wr_data;
  } seq_out_t;

endpackage

// ----- hw/rtl/adc_channel_scan_sequencer.sv -----
// Round-robin scan sequencer for a multi-channel converter.
// The slave stream carries one handler tick per transfer:
//   s_tdata = {query_channel, result_high_byte, result_low_byte, converter_busy}.
// The master stream returns one result per tick:
//   m_tdata = {query_value, sample_stored, mux_channel, start_conversion}.
// Each tick steps the scan machine once (init, sampling, config, wait, read),
// stores the converter result in the channel buffer on the read step and
// returns the buffered value of the query channel, including this tick's write.
// A result is valid in the cycle after its input transfer. Throughput
// is one tick per cycle while the receiver keeps up, set by the single
// output register; a new tick is taken whenever the output register is
// empty or is being drained in the same cycle.
// When the receiver stalls, the result stays in the output register and
// s_tready drops until it is taken.
// Reset (synchronous, active high) puts the machine in the init step with
// the channel pointer on the last channel, clears the buffer and restores
// the registers: all channels enabled, no sampling delay, ten-bit mode.
// Registers (APB, 4-byte stride): 0 enable mask, 1 sampling ticks,
// 2 eight-bit mode. Change them only while no tick is outstanding.
module adc_channel_scan_sequencer #(
  parameter int CHANNELS = acss_pkg::CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [0] converter_busy, [8:1] result_low_byte, [16:9] result_high_byte,
  // [19:17] query_channel, [23:20] zero
  input  logic [23:0]                   s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [0] start_conversion, [3:1] mux_channel, [4] sample_stored,
  // [20:5] query_value, [23:21] zero
  output logic [23:0]                   m_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [acss_pkg::ADDR_W-1:0]   paddr,
  input  logic [acss_pkg::PDATA_W-1:0]  pwdata,
  output logic [acss_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import acss_pkg::*;

  cfg_t                cfg;
  seq_out_t            res;
  logic                accept;
  logic                cfg_wr;
  logic [REG_W-1:0]    reg_idx;
  logic [SAMPLE_W-1:0] query_value;
  logic [20:0]         out_word;

  // Stream handshake: the output register frees up as it is drained.
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // Configuration registers.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable_mask    <= '1;
      cfg.sampling_ticks <= '0;
      cfg.eight_bit_mode <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_ENABLE_MASK: cfg.enable_mask    <= pwdata[MASK_W-1:0];
        REG_SAMPLING:    cfg.sampling_ticks <= pwdata[CNT_W-1:0];
        REG_EIGHT_BIT:   cfg.eight_bit_mode <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_ENABLE_MASK: prdata = {{(PDATA_W - MASK_W){1'b0}}, cfg.enable_mask};
      REG_SAMPLING:    prdata = {{(PDATA_W - CNT_W){1'b0}}, cfg.sampling_ticks};
      REG_EIGHT_BIT:   prdata = {{(PDATA_W - 1){1'b0}}, cfg.eight_bit_mode};
      default:         prdata = '0;
    endcase
  end

  // Scan machine.
  acss_seq #(
    .CHANNELS(CHANNELS)
  ) u_seq (
    .clk    (clk),
    .rst    (rst),
    .advance(accept),
    .busy   (s_tdata[0]),
    .lo     (s_tdata[8:1]),
    .hi     (s_tdata[16:9]),
    .cfg    (cfg),
    .res    (res)
  );

  // Channel result buffer.
  acss_buf #(
    .CHANNELS(CHANNELS)
  ) u_buf (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (accept && res.stored),
    .wr_ch      (res.wr_ch),
    .wr_data    (res.wr_data),
    .query      (s_tdata[19:17]),
    .query_value(query_value)
  );

  assign out_word = {query_value, res.stored, res.mux, res.start};

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {3'b000, out_word};
    end
  end

endmodule

// ----- hw/rtl/acss_seq.sv -----
module acss_seq #(
  parameter int CHANNELS = acss_pkg::CHANNELS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     advance,
  input  logic                     busy,
  input  logic [acss_pkg::BYTE_W-1:0] lo,
  input  logic [acss_pkg::BYTE_W-1:0] hi,
  input  acss_pkg::cfg_t           cfg,
  output acss_pkg::seq_out_t       res
);
  import acss_pkg::*;

  localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

  step_t            step, step_next;
  logic [CH_W-1:0]  cur, cur_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CH_W-1:0]  mux, mux_next;
  logic [CH_W-1:0]  ch_inc;
  logic [7:0]       mask_ext;
  logic             inc_enabled;

  // Next channel in round-robin order; channels without a mask bit read as disabled.
  assign ch_inc      = (cur == LAST_CH) ? '0 : cur + CH_W'(1);
  assign mask_ext    = {{(8 - MASK_W){1'b0}}, cfg.enable_mask};
  assign inc_enabled = mask_ext[ch_inc];

  // Next step.
  always_comb begin
    step_next = step;
    unique case (step)
      STEP_INIT:     if (inc_enabled) step_next = STEP_SAMPLING;
      STEP_SAMPLING: if (count == '0) step_next = STEP_CONFIG;
      STEP_CONFIG:   step_next = STEP_WAIT;
      STEP_WAIT:     if (!busy) step_next = STEP_READ;
      STEP_READ:     step_next = STEP_INIT;
      default:       step_next = STEP_INIT;
    endcase
  end

  // Data path and per-tick outputs.
  always_comb begin
    cur_next    = cur;
    count_next  = count;
    mux_next    = mux;
    res.start   = 1'b0;
    res.stored  = 1'b0;
    res.wr_ch   = cur;
    res.wr_data = cfg.eight_bit_mode ? {{(SAMPLE_W - BYTE_W){1'b0}}, hi} : {hi, lo};
    unique case (step)
      STEP_INIT: begin
        cur_next = ch_inc;
        if (inc_enabled) count_next = cfg.sampling_ticks;
      end
      STEP_SAMPLING: begin
        if (count != '0) count_next = count - CNT_W'(1);
      end
      STEP_CONFIG: begin
        mux_next  = cur;
        res.start = 1'b1;
      end
      STEP_READ: begin
        res.stored = 1'b1;
      end
      default: begin
      end
    endcase
    res.mux = mux_next;
  end

  // State registers advance once per accepted tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      step  <= STEP_INIT;
      cur   <= LAST_CH;
      count <= '0;
      mux   <= '0;
    end else if (advance) begin
      step  <= step_next;
      cur   <= cur_next;
      count <= count_next;
      mux   <= mux_next;
    end
  end

endmodule

// ----- hw/rtl/acss_buf.sv -----
module acss_buf #(
  parameter int CHANNELS = acss_pkg::CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [acss_pkg::CH_W-1:0]     wr_ch,
  input  logic [acss_pkg::SAMPLE_W-1:0] wr_data,
  input  logic [acss_pkg::CH_W-1:0]     query,
  output logic [acss_pkg::SAMPLE_W-1:0] query_value
);
  import acss_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [SAMPLE_W-1:0] samples [CHANNELS];
  logic [SAMPLE_W-1:0] rd_data;

  // Per-channel result store, cleared at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) samples[i] <= '0;
    end else if (wr_en) begin
      samples[wr_ch[IDX_W-1:0]] <= wr_data;
    end
  end

  // The query sees this tick's write, and out-of-range channels read as zero.
  // The range check is one bit wider so that a full set of eight channels fits.
  always_comb begin
    rd_data = '0;
    if ({1'b0, query} < (CH_W + 1)'(CHANNELS)) rd_data = samples[query[IDX_W-1:0]];
    if (wr_en && (wr_ch == query)) rd_data = wr_data;
  end

  assign query_value = rd_data;

endmodule

// ----- tb/tb.sv -----
module tb;
  import acss_pkg::*;

  localparam int CHANNELS = CHANNELS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [REG_W-1:0] REG_UNUSED = 2'd3;

  // One expected result of a handler tick.
  typedef struct {
    logic                start;
    logic [CH_W-1:0]     mux;
    logic                stored;
    logic [SAMPLE_W-1:0] value;
  } scan_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // [0] converter_busy, [8:1] result_low_byte, [16:9] result_high_byte,
  // [19:17] query_channel, [23:20] zero
  logic [23:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b1;
  // [0] start_conversion, [3:1] mux_channel, [4] sample_stored,
  // [20:5] query_value, [23:21] zero
  logic [23:0] m_tdata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  // Register copies as the sequencer should see them.
  logic [MASK_W-1:0] mask_reg = 6'h3F;
  logic [CNT_W-1:0] ticks_reg = '0;
  logic eight_reg = 1'b0;

  // Predicted sequencer state.
  step_t step_now = STEP_INIT;
  logic [CH_W-1:0] chan_now = CH_W'(CHANNELS - 1);
  logic [CNT_W-1:0] count_now = '0;
  logic [SAMPLE_W-1:0] sample_mem [CHANNELS];
  logic [CH_W-1:0] mux_now = '0;

  scan_out_t tick_results_due[$];
  int errors = 0;
  int cycle_count = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int conv_left = 0;

  adc_channel_scan_sequencer dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #2 clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Receiver backpressure.
  always @(posedge clk) begin
    if (stall_pct == 0) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic flag_error(input string what);
    errors++;
    if (errors <= 10) begin
      $display("%s", what);
    end
  endtask

  // Advance the scan machine by one handler tick and return its outputs.
  function automatic scan_out_t scan_tick(input logic busy, input logic [7:0] lo,
                                          input logic [7:0] hi, input logic [2:0] query);
    scan_out_t res;
    int nxt;
    res.start = 1'b0;
    res.stored = 1'b0;
    case (step_now)
      STEP_INIT: begin
        nxt = int'(chan_now) + 1;
        if (nxt >= CHANNELS) nxt = 0;
        chan_now = CH_W'(nxt);
        // Channels beyond the mask width are never enabled.
        if (nxt < MASK_W && mask_reg[nxt]) begin
          step_now = STEP_SAMPLING;
          count_now = ticks_reg;
        end
      end
      STEP_SAMPLING: begin
        if (count_now != 0) count_now = count_now - 1'b1;
        else step_now = STEP_CONFIG;
      end
      STEP_CONFIG: begin
        mux_now = chan_now;
        res.start = 1'b1;
        step_now = STEP_WAIT;
      end
      STEP_WAIT: begin
        if (!busy) step_now = STEP_READ;
      end
      STEP_READ: begin
        if (int'(chan_now) < CHANNELS) begin
          sample_mem[chan_now] = eight_reg ? {8'h00, hi} : {hi, lo};
        end
        res.stored = 1'b1;
        step_now = STEP_INIT;
      end
      default: step_now = STEP_INIT;
    endcase
    res.mux = mux_now;
    res.value = (int'(query) < CHANNELS) ? sample_mem[query] : '0;
    return res;
  endfunction

  // Send one tick, record its expected result, and maybe idle afterwards.
  task automatic send_tick(input logic busy, input logic [7:0] lo, input logic [7:0] hi,
                           input logic [2:0] query, output logic started);
    scan_out_t due;
    s_tvalid <= 1'b1;
    s_tdata <= {4'b0000, query, hi, lo, busy};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    due = scan_tick(busy, lo, hi, query);
    tick_results_due.push_back(due);
    started = due.start;
    if ($urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every expected result has come back.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (tick_results_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_W-1:0] idx, input logic [PDATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ENABLE_MASK: mask_reg = data[MASK_W-1:0];
      REG_SAMPLING:    ticks_reg = data[CNT_W-1:0];
      REG_EIGHT_BIT:   eight_reg = data[0];
      default: ;
    endcase
  endtask

  task automatic check_reg(input logic [REG_W-1:0] idx, input logic [PDATA_W-1:0] want);
    logic [PDATA_W-1:0] got;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== want) begin
      flag_error($sformatf("register %0d read: expected %h, got %h", idx, want, got));
    end
  endtask

  task automatic check_all_regs();
    check_reg(REG_ENABLE_MASK, PDATA_W'(mask_reg));
    check_reg(REG_SAMPLING, PDATA_W'(ticks_reg));
    check_reg(REG_EIGHT_BIT, PDATA_W'(eight_reg));
  endtask

  // Write all three registers with junk above their widths, then read them back.
  task automatic set_scan_config(input logic [MASK_W-1:0] mask, input logic [CNT_W-1:0] ticks,
                                 input logic eight);
    write_reg(REG_ENABLE_MASK, ($urandom() << MASK_W) | PDATA_W'(mask));
    write_reg(REG_SAMPLING, ($urandom() << CNT_W) | PDATA_W'(ticks));
    write_reg(REG_EIGHT_BIT, ($urandom() << 1) | PDATA_W'(eight));
    check_all_regs();
  endtask

  // Compare each result transfer against the oldest expectation.
  always @(posedge clk) begin
    scan_out_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (tick_results_due.size() == 0) begin
        flag_error($sformatf("unexpected result %h", m_tdata));
      end else begin
        want = tick_results_due.pop_front();
        if (m_tdata[0] !== want.start || m_tdata[3:1] !== want.mux ||
            m_tdata[4] !== want.stored || m_tdata[20:5] !== want.value) begin
          flag_error($sformatf({"result mismatch: expected start=%0d mux=%0d stored=%0d ",
                                "value=%h, got start=%0d mux=%0d stored=%0d value=%h"},
                               want.start, want.mux, want.stored, want.value,
                               m_tdata[0], m_tdata[3:1], m_tdata[4], m_tdata[20:5]));
        end
      end
    end
  end

  // Default registers after reset: first samples of channels 0 (full-scale
  // bytes) and 1 (zero low byte), a busy wait and out-of-range queries.
  task automatic test_default_scan();
    logic started;
    check_all_regs();
    for (int i = 0; i < 11; i++) begin
      send_tick(i == 2 || i == 3, (i < 8) ? 8'hFF : 8'h00, 8'hFF, 3'(i), started);
    end
    wait_idle();
  endtask

  // No channel enabled: the pointer cycles and nothing is converted. A write
  // to the unused register index must change nothing.
  task automatic test_no_channel();
    logic started;
    set_scan_config('0, '0, 1'b0);
    write_reg(REG_UNUSED, $urandom());
    check_all_regs();
    for (int i = 0; i < 4; i++) begin
      send_tick(1'($urandom()), 8'($urandom()), 8'($urandom()), 3'($urandom()), started);
    end
    wait_idle();
  endtask

  // Eight-bit mode with a short sampling delay on channels 0 and 5.
  task automatic test_eight_bit_sampling();
    logic started;
    set_scan_config(6'b100001, 8'd2, 1'b1);
    for (int i = 0; i < 10; i++) begin
      send_tick(1'b0, 8'($urandom()), 8'h80 | 8'(i), 3'(i % CHANNELS), started);
    end
    wait_idle();
  endtask

  // Converter modeled as busy for a few ticks after each start, with
  // occasional glitches on the busy flag.
  task automatic run_random_ticks(input int count);
    logic started;
    logic busy;
    for (int i = 0; i < count; i++) begin
      busy = (conv_left != 0);
      if ($urandom_range(0, 9) == 0) busy = ~busy;
      send_tick(busy, 8'($urandom()), 8'($urandom()), 3'($urandom_range(0, 7)), started);
      if (conv_left != 0) conv_left--;
      if (started) conv_left = $urandom_range(0, 5);
    end
  endtask

  // Four idling phases, each split into several register settings.
  task automatic test_random_scan();
    logic [MASK_W-1:0] mask;
    logic [CNT_W-1:0] ticks;
    logic eight;
    conv_left = 0;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 64; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 64; end
        default: begin gap_pct = 30; stall_pct = 30; end
      endcase
      for (int j = 0; j < 4; j++) begin
        mask = (j == 0) ? 6'h3F : 6'($urandom_range(0, 63));
        ticks = ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 3));
        eight = 1'($urandom());
        // Longest sampling delay on a single channel.
        if (p == 1 && j == 1) begin
          mask = 6'(1 << $urandom_range(0, MASK_W - 1));
          ticks = 8'hFF;
        end
        if (p == 2 && j == 2) mask = '0;
        if (p == 3 && j == 3) begin
          mask = 6'h3F;
          ticks = '0;
          eight = 1'b0;
        end
        set_scan_config(mask, ticks, eight);
        run_random_ticks((ticks == 8'hFF) ? 280 : 70);
        wait_idle();
      end
    end
  endtask

  initial begin
    for (int c = 0; c < CHANNELS; c++) sample_mem[c] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_scan();
    test_no_channel();
    test_eight_bit_sampling();
    test_random_scan();
    wait_idle();
    if (errors == 0 && tick_results_due.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/acss_pkg.sv
hw/rtl/acss_seq.sv
hw/rtl/acss_buf.sv
hw/rtl/adc_channel_scan_sequencer.sv
tb/tb.sv
